### rtl/hkrd_pkg.sv
// Shared constants and types for the keyboard report press and release detector.
package hkrd_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int KEY_W     = 8;
	localparam int MOD_W     = 8;
	localparam int EVENTS    = 2 * KEY_SLOTS;
	localparam int IDX_W     = $clog2(EVENTS);

	localparam logic EV_RELEASE = 1'b0;
	localparam logic EV_PRESS   = 1'b1;

	typedef logic [KEY_W-1:0] key_t;
	typedef key_t [KEY_SLOTS-1:0] key_set_t;
	typedef key_t [EVENTS-1:0] lane_keys_t;

	typedef struct packed {
		logic                load;
		logic [EVENTS-1:0]   mask;
		logic [MOD_W-1:0]    mods;
	} load_t;

endpackage

### rtl/hkrd_lane.sv
// One comparison lane: flags a nonzero key that is absent from the other report.
module hkrd_lane (
	input  hkrd_pkg::key_t     key,
	input  hkrd_pkg::key_set_t other,
	output logic               changed
);

	logic found;

	always_comb begin
		found = 1'b0;
		for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++) begin
			if (other[i] == key) begin
				found = 1'b1;
			end
		end
		changed = (key != '0) && !found;
	end

endmodule

### rtl/hkrd_drain.sv
// Merge stage: holds the lane flags of one report and sends one event per beat.
module hkrd_drain (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hkrd_pkg::load_t                    ld,
	input  hkrd_pkg::lane_keys_t               ld_keys,
	output logic                               free,
	output logic                               evt_valid,
	input  logic                               evt_stall,
	output logic                               event_type,
	output logic [hkrd_pkg::KEY_W-1:0]         usage_id,
	output logic [hkrd_pkg::MOD_W-1:0]         event_modifiers,
	output logic                               last_event
);

	logic [hkrd_pkg::EVENTS-1:0] pend_q;
	hkrd_pkg::lane_keys_t        keys_q;
	logic [hkrd_pkg::MOD_W-1:0]  mods_q;

	logic                        valid_q;
	logic                        type_q;
	hkrd_pkg::key_t              id_q;
	logic [hkrd_pkg::MOD_W-1:0]  omods_q;
	logic                        last_q;

	logic [hkrd_pkg::IDX_W-1:0]  pick;
	logic [hkrd_pkg::EVENTS-1:0] rest;
	logic                        advance;

	always_comb begin
		pick = '0;
		for (int i = hkrd_pkg::EVENTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				pick = hkrd_pkg::IDX_W'(i);
			end
		end
		rest    = pend_q & ~(hkrd_pkg::EVENTS'(1) << pick);
		advance = (pend_q != '0) && (!valid_q || !evt_stall);
		free    = (pend_q == '0) || (advance && (rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ld.load) begin
				pend_q <= ld.mask;
			end else if (advance) begin
				pend_q <= rest;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (!evt_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			keys_q <= ld_keys;
			mods_q <= ld.mods;
		end
		if (advance) begin
			type_q  <= (pick >= hkrd_pkg::IDX_W'(hkrd_pkg::KEY_SLOTS)) ?
				hkrd_pkg::EV_PRESS : hkrd_pkg::EV_RELEASE;
			id_q    <= keys_q[pick];
			omods_q <= mods_q;
			last_q  <= (rest == '0);
		end
	end

	assign evt_valid       = valid_q;
	assign event_type      = type_q;
	assign usage_id        = id_q;
	assign event_modifiers = omods_q;
	assign last_event      = last_q;

endmodule

### rtl/hid_keyboard_report_diff.sv
// Top level of the boot keyboard report press and release detector.
//
// A report beat enters on req_valid and req_stall with the modifier byte, six
// usage IDs and report_full. Twelve lanes compare it with the previous keys in
// the same cycle: six look for released keys and six for pressed keys. The
// merge stage then sends the events, releases first and then presses, each in
// slot order, one beat per cycle while evt_stall is low, on evt_valid and
// evt_stall. last_event marks the final event of a report. A report with
// report_full low, or one without changes, gives no beats. Each event is held
// in the pending flags of the merge stage and then in the output register.
// The next report is taken in the cycle that the last event of the one before
// moves to the output register. Reset clears the previous keys to zero and
// drops any pending events. While the receiver stalls, the output beat holds
// and req_stall rises once events are pending.
module hid_keyboard_report_diff (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        report_full,
	input  logic [hkrd_pkg::MOD_W-1:0]  modifier_mask,
	input  logic [hkrd_pkg::KEY_W-1:0]  key_0,
	input  logic [hkrd_pkg::KEY_W-1:0]  key_1,
	input  logic [hkrd_pkg::KEY_W-1:0]  key_2,
	input  logic [hkrd_pkg::KEY_W-1:0]  key_3,
	input  logic [hkrd_pkg::KEY_W-1:0]  key_4,
	input  logic [hkrd_pkg::KEY_W-1:0]  key_5,
	output logic                        evt_valid,
	input  logic                        evt_stall,
	output logic                        event_type,
	output logic [hkrd_pkg::KEY_W-1:0]  usage_id,
	output logic [hkrd_pkg::MOD_W-1:0]  event_modifiers,
	output logic                        last_event
);

	hkrd_pkg::key_set_t          prev_q;
	hkrd_pkg::key_set_t          cur;
	hkrd_pkg::lane_keys_t        lane_keys;
	logic [hkrd_pkg::EVENTS-1:0] hits;
	hkrd_pkg::load_t             ld;
	logic                        free;
	logic                        take;

	assign cur[0] = key_0;
	assign cur[1] = key_1;
	assign cur[2] = key_2;
	assign cur[3] = key_3;
	assign cur[4] = key_4;
	assign cur[5] = key_5;

	for (genvar g = 0; g < hkrd_pkg::KEY_SLOTS; g++) begin : g_lane
		hkrd_lane u_rel (
			.key     (prev_q[g]),
			.other   (cur),
			.changed (hits[g])
		);
		hkrd_lane u_prs (
			.key     (cur[g]),
			.other   (prev_q),
			.changed (hits[hkrd_pkg::KEY_SLOTS + g])
		);
		assign lane_keys[g]                      = prev_q[g];
		assign lane_keys[hkrd_pkg::KEY_SLOTS + g] = cur[g];
	end

	assign req_stall = !free;
	assign take      = req_valid && free && report_full;

	always_comb begin
		ld.load = take;
		ld.mask = hits;
		ld.mods = modifier_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (take) begin
			prev_q <= cur;
		end
	end

	hkrd_drain u_drain (
		.clk             (clk),
		.arst_n          (arst_n),
		.ld              (ld),
		.ld_keys         (lane_keys),
		.free            (free),
		.evt_valid       (evt_valid),
		.evt_stall       (evt_stall),
		.event_type      (event_type),
		.usage_id        (usage_id),
		.event_modifiers (event_modifiers),
		.last_event      (last_event)
	);

endmodule

### sim/tb_top.sv
// Self-checking testbench for the keyboard report press and release detector.
import hkrd_pkg::*;

typedef struct packed {
	logic             kind;
	key_t             usage;
	logic [MOD_W-1:0] mods;
	logic             last;
} key_event_t;

class key_event_board;
	key_set_t   held_keys;
	key_event_t awaited_events[$];
	int         failures;

	function new();
		held_keys = '0;
		failures = 0;
	endfunction

	function bit has_key(key_set_t set, key_t k);
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (set[i] == k)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function void note_report(logic full, logic [MOD_W-1:0] mods, key_set_t keys);
		key_event_t ev;
		key_event_t found[$];
		if (!full)
			return;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (held_keys[i] != 0 && !has_key(keys, held_keys[i])) begin
				ev.kind = EV_RELEASE;
				ev.usage = held_keys[i];
				ev.mods = mods;
				ev.last = 1'b0;
				found.push_back(ev);
			end
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (keys[i] != 0 && !has_key(held_keys, keys[i])) begin
				ev.kind = EV_PRESS;
				ev.usage = keys[i];
				ev.mods = mods;
				ev.last = 1'b0;
				found.push_back(ev);
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			awaited_events.push_back(found[i]);
		held_keys = keys;
	endfunction

	function void check_event(key_event_t got);
		key_event_t want;
		if (awaited_events.size() == 0) begin
			$error("unexpected event: type %0d usage 0x%02h", got.kind, got.usage);
			failures++;
			return;
		end
		want = awaited_events.pop_front();
		if (got.kind !== want.kind) begin
			$error("event_type: expected %0d, got %0d", want.kind, got.kind);
			failures++;
		end
		if (got.usage !== want.usage) begin
			$error("usage_id: expected 0x%02h, got 0x%02h", want.usage, got.usage);
			failures++;
		end
		if (got.mods !== want.mods) begin
			$error("event_modifiers: expected 0x%02h, got 0x%02h", want.mods, got.mods);
			failures++;
		end
		if (got.last !== want.last) begin
			$error("last_event: expected %0d, got %0d", want.last, got.last);
			failures++;
		end
	endfunction
endclass

module tb_top;
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             report_full = 1'b0;
	logic [MOD_W-1:0] modifier_mask = '0;
	key_t             key_0 = '0;
	key_t             key_1 = '0;
	key_t             key_2 = '0;
	key_t             key_3 = '0;
	key_t             key_4 = '0;
	key_t             key_5 = '0;
	logic             evt_valid;
	logic             evt_stall = 1'b0;
	logic             event_type;
	key_t             usage_id;
	logic [MOD_W-1:0] event_modifiers;
	logic             last_event;

	key_event_board board = new();
	key_set_t       typed_keys = '0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             hold_request = 0;
	int             hold_left = 0;

	hid_keyboard_report_diff dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.report_full(report_full),
		.modifier_mask(modifier_mask),
		.key_0(key_0),
		.key_1(key_1),
		.key_2(key_2),
		.key_3(key_3),
		.key_4(key_4),
		.key_5(key_5),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.event_type(event_type),
		.usage_id(usage_id),
		.event_modifiers(event_modifiers),
		.last_event(last_event)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic key_set_t slots(key_t k0, key_t k1, key_t k2, key_t k3, key_t k4,
			key_t k5);
		key_set_t s;
		s[0] = k0;
		s[1] = k1;
		s[2] = k2;
		s[3] = k3;
		s[4] = k4;
		s[5] = k5;
		return s;
	endfunction

	// Most slots reuse, clear or pick from a small pool so that keys overlap
	// between reports, move between slots and repeat within one report.
	function automatic key_set_t next_key_set();
		key_set_t s;
		int r;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			r = $urandom_range(99);
			if (r < 35)
				s[i] = typed_keys[$urandom_range(KEY_SLOTS - 1)];
			else if (r < 55)
				s[i] = '0;
			else if (r < 85)
				s[i] = key_t'($urandom_range(12, 1));
			else
				s[i] = key_t'($urandom_range(255));
		end
		return s;
	endfunction

	task automatic send_report(logic full, logic [MOD_W-1:0] mods, key_set_t keys);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		report_full <= full;
		modifier_mask <= mods;
		key_0 <= keys[0];
		key_1 <= keys[1];
		key_2 <= keys[2];
		key_3 <= keys[3];
		key_4 <= keys[4];
		key_5 <= keys[5];
		do
			@(posedge clk);
		while (req_stall);
		board.note_report(full, mods, keys);
		if (full)
			typed_keys = keys;
	endtask

	task automatic run_phase(int count, int s_idle, int r_idle);
		key_set_t keys;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		repeat (count) begin
			if ($urandom_range(99) < 12) begin
				for (int i = 0; i < KEY_SLOTS; i++)
					keys[i] = key_t'($urandom_range(255));
				send_report(1'b0, MOD_W'($urandom_range(255)), keys);
			end else begin
				keys = next_key_set();
				send_report(1'b1, MOD_W'($urandom_range(255)), keys);
			end
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && evt_valid && !evt_stall)
				board.check_event({event_type, usage_id, event_modifiers, last_event});
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				evt_stall <= 1'b1;
			end else begin
				evt_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 74;
		send_report(1'b1, 8'h00, slots(0, 0, 0, 0, 0, 0));
		send_report(1'b1, 8'hff, slots(1, 2, 3, 4, 5, 6));
		send_report(1'b0, 8'h3c, slots(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_report(1'b1, 8'h01, slots(6, 5, 4, 3, 2, 1));
		send_report(1'b1, 8'ha5, slots(8'hff, 8'hfe, 8'hfd, 8'hfc, 8'hfb, 8'hfa));
		send_report(1'b1, 8'h80, slots(0, 0, 0, 0, 0, 0));
		send_report(1'b1, 8'h7f, slots(8'h80, 8'h80, 0, 8'h7f, 8'h7f, 8'h80));
		send_report(1'b1, 8'h02, slots(0, 0, 0, 0, 0, 8'h7f));
		send_report(1'b1, 8'h5a, slots(8'h55, 8'haa, 0, 0, 0, 0));
		send_report(1'b0, 8'hff, slots(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_report(1'b1, 8'h5a, slots(8'haa, 0, 0, 0, 0, 8'h55));
		send_report(1'b1, 8'hff, slots(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_report(1'b1, 8'h00, slots(0, 0, 0, 0, 0, 0));

		run_phase(130, 14, 74);
		run_phase(130, 74, 14);
		hold_request = 90;
		run_phase(140, 0, 0);

		req_valid <= 1'b0;
		while (board.awaited_events.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (board.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### hid_keyboard_report_diff.f
rtl/hkrd_pkg.sv
rtl/hkrd_lane.sv
rtl/hkrd_drain.sv
rtl/hid_keyboard_report_diff.sv
sim/tb_top.sv
